### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### hw/rtl/bsc_pkg.sv
// Package for the barometric sensor compensation block: widths, codes, states.
// No dependencies.
`timescale 1ns / 1ps
package bsc_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned RawW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CalRegs = 5;

  localparam logic [CfgIdxW-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_B1_B2   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MC_MD   = 3'd4;

  localparam logic CMD_TEMP  = 1'b0;
  localparam logic CMD_PRESS = 1'b1;

  // Divider control and status between top and divider.
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DataW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T0, ST_T1, ST_T2, ST_TDIV, ST_TWAIT, ST_T3,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
    ST_PDIV, ST_PWAIT, ST_P9, ST_P10, ST_P11, ST_P12, ST_P13,
    ST_OUT
  } state_t;
endpackage

### hw/rtl/bsc_divider.sv
// Unsigned 32-bit restoring divider, one quotient bit a cycle.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  bsc_pkg::div_req_t  req,
  output bsc_pkg::div_rsp_t  rsp
);
  localparam int unsigned CntW = $clog2(bsc_pkg::DataW + 1);

  logic [bsc_pkg::DataW-1:0] quo_r, quo_nxt;
  logic [bsc_pkg::DataW-1:0] rem_r, rem_nxt;
  logic [bsc_pkg::DataW-1:0] dvs_r, dvs_nxt;
  logic [CntW-1:0]           cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [bsc_pkg::DataW:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[bsc_pkg::DataW-1]} - {1'b0, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = CntW'(bsc_pkg::DataW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[bsc_pkg::DataW]) begin
        rem_nxt = trial[bsc_pkg::DataW-1:0];
        quo_nxt = {quo_r[bsc_pkg::DataW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[bsc_pkg::DataW-2:0], quo_r[bsc_pkg::DataW-1]};
        quo_nxt = {quo_r[bsc_pkg::DataW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule

### hw/rtl/barometric_sensor_compensation.sv
// Top level: sequencer, shared 32x32 multiplier and shifter, calibration registers.
// Depends on bsc_pkg, bsc_divider and assert_macros.svh.
//
//   channel  dir  tdata / fields                   tuser
//   in_      in   [15:0] raw_reading               cmd
//   out_     out  [31:0] comp_value                [0] value_kind [1] divide_fault
//   cfg_     in   index + 32-bit calibration word  -
//
// For temperature and pressure the serial divider takes most of the time; the
// rest is one multiply-shift step a cycle.
// Reset (rst_n low, synchronous) clears calibration and stored b5.
// in_tready is high only in idle; a waiting result holds until out_tready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module barometric_sensor_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bsc_pkg::RawW-1:0]          in_tdata,  // [15:0] raw_reading
  input  logic                              in_tuser,  // [0] cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bsc_pkg::DataW-1:0]         out_tdata, // [31:0] comp_value
  output logic [1:0]                        out_tuser, // [0] value_kind [1] divide_fault
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bsc_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [bsc_pkg::DataW-1:0]         cfg_data
);
  localparam int unsigned W = bsc_pkg::DataW;

  bsc_pkg::state_t st_r, st_nxt;
  logic [W-1:0] cal_r [bsc_pkg::CalRegs];
  logic [W-1:0] b5_r;
  logic [W-1:0] raw_r;
  logic         cmd_r;
  logic [W-1:0] a_r, b_r, c_r, d_r;  // scratch
  logic [W-1:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [W-1:0] res_r, res_nxt;
  logic         flt_r, flt_nxt;
  logic         b5_we;
  logic         neg_r, neg_nxt;

  // shared unit: wrapping multiply then arithmetic or logical right shift
  logic [W-1:0] mul_a, mul_b, mul_p, sh_out;
  logic [4:0]   sh_amt;
  logic         sh_arith;
  logic [2*W-1:0] prod_full;

  bsc_pkg::div_req_t dreq;
  bsc_pkg::div_rsp_t drsp;

  bsc_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  function automatic logic [W-1:0] sx16(input logic [15:0] v);
    sx16 = {{(W-16){v[15]}}, v};
  endfunction

  logic [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(cal_r[bsc_pkg::REG_AC1_AC2][31:16]);
  assign ac2 = sx16(cal_r[bsc_pkg::REG_AC1_AC2][15:0]);
  assign ac3 = sx16(cal_r[bsc_pkg::REG_AC3_AC4][31:16]);
  assign ac4 = {16'd0, cal_r[bsc_pkg::REG_AC3_AC4][15:0]};
  assign ac5 = {16'd0, cal_r[bsc_pkg::REG_AC5_AC6][31:16]};
  assign ac6 = {16'd0, cal_r[bsc_pkg::REG_AC5_AC6][15:0]};
  assign b1  = sx16(cal_r[bsc_pkg::REG_B1_B2][31:16]);
  assign b2  = sx16(cal_r[bsc_pkg::REG_B1_B2][15:0]);
  assign mc  = sx16(cal_r[bsc_pkg::REG_MC_MD][31:16]);
  assign md  = sx16(cal_r[bsc_pkg::REG_MC_MD][15:0]);

  assign prod_full = mul_a * mul_b;
  assign mul_p     = prod_full[W-1:0];
  assign sh_out    = sh_arith ? W'($signed(mul_p) >>> sh_amt) : (mul_p >> sh_amt);

  assign in_tready  = (st_r == bsc_pkg::ST_IDLE);
  assign cfg_ready  = (st_r == bsc_pkg::ST_IDLE);
  assign out_tvalid = (st_r == bsc_pkg::ST_OUT);
  assign out_tdata  = res_r;
  assign out_tuser  = {flt_r, cmd_r};

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      bsc_pkg::ST_IDLE:  if (in_tvalid) st_nxt = in_tuser ? bsc_pkg::ST_P0 : bsc_pkg::ST_T0;
      bsc_pkg::ST_T0:    st_nxt = bsc_pkg::ST_T1;
      bsc_pkg::ST_T1:    st_nxt = bsc_pkg::ST_T2;
      bsc_pkg::ST_T2:    st_nxt = (b_r == '0) ? bsc_pkg::ST_OUT : bsc_pkg::ST_TDIV;
      bsc_pkg::ST_TDIV:  st_nxt = bsc_pkg::ST_TWAIT;
      bsc_pkg::ST_TWAIT: if (drsp.done) st_nxt = bsc_pkg::ST_T3;
      bsc_pkg::ST_T3:    st_nxt = bsc_pkg::ST_OUT;
      bsc_pkg::ST_P0:    st_nxt = bsc_pkg::ST_P1;
      bsc_pkg::ST_P1:    st_nxt = bsc_pkg::ST_P2;
      bsc_pkg::ST_P2:    st_nxt = bsc_pkg::ST_P3;
      bsc_pkg::ST_P3:    st_nxt = bsc_pkg::ST_P4;
      bsc_pkg::ST_P4:    st_nxt = bsc_pkg::ST_P5;
      bsc_pkg::ST_P5:    st_nxt = bsc_pkg::ST_P6;
      bsc_pkg::ST_P6:    st_nxt = bsc_pkg::ST_P7;
      bsc_pkg::ST_P7:    st_nxt = bsc_pkg::ST_P8;
      bsc_pkg::ST_P8:    st_nxt = (a_nxt == '0) ? bsc_pkg::ST_OUT : bsc_pkg::ST_PDIV;
      bsc_pkg::ST_PDIV:  st_nxt = bsc_pkg::ST_PWAIT;
      bsc_pkg::ST_PWAIT: if (drsp.done) st_nxt = bsc_pkg::ST_P9;
      bsc_pkg::ST_P9:    st_nxt = bsc_pkg::ST_P10;
      bsc_pkg::ST_P10:   st_nxt = bsc_pkg::ST_P11;
      bsc_pkg::ST_P11:   st_nxt = bsc_pkg::ST_P12;
      bsc_pkg::ST_P12:   st_nxt = bsc_pkg::ST_P13;
      bsc_pkg::ST_P13:   st_nxt = bsc_pkg::ST_OUT;
      bsc_pkg::ST_OUT:   if (out_tready) st_nxt = bsc_pkg::ST_IDLE;
      default:           st_nxt = bsc_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r;
    res_nxt = res_r; flt_nxt = flt_r; neg_nxt = neg_r;
    b5_we = 1'b0;
    mul_a = '0; mul_b = '0; sh_amt = '0; sh_arith = 1'b1;
    dreq = '0;
    case (st_r)
      bsc_pkg::ST_IDLE: begin
        res_nxt = '0;
        flt_nxt = 1'b0;
      end
      // x1 = asr((raw - ac6) * ac5, 15)
      bsc_pkg::ST_T0: begin
        mul_a = raw_r - ac6; mul_b = ac5; sh_amt = 5'd15;
        a_nxt = sh_out;
      end
      // den = x1 + md; num = mc * 2048
      bsc_pkg::ST_T1: begin
        mul_a = mc; mul_b = W'(2048);
        c_nxt = mul_p;
        b_nxt = a_r + md;
      end
      bsc_pkg::ST_T2: if (b_r == '0) flt_nxt = 1'b1;
      bsc_pkg::ST_TDIV: begin
        neg_nxt = c_r[W-1] ^ b_r[W-1];
        dreq.start    = 1'b1;
        dreq.dividend = c_r[W-1] ? (W'(0) - c_r) : c_r;
        dreq.divisor  = b_r[W-1] ? (W'(0) - b_r) : b_r;
      end
      bsc_pkg::ST_T3: begin
        d_nxt = a_r + (neg_r ? (W'(0) - drsp.quotient) : drsp.quotient);
        b5_we = 1'b1;
        mul_a = d_nxt + W'(8); mul_b = W'(1); sh_amt = 5'd4;
        res_nxt = sh_out;
      end
      // b6 and sq
      bsc_pkg::ST_P0: begin
        a_nxt = b5_r - W'(4000);
      end
      bsc_pkg::ST_P1: begin
        mul_a = a_r; mul_b = a_r; sh_amt = 5'd12;
        b_nxt = sh_out;
      end
      // x1 = asr(b2*sq,11)
      bsc_pkg::ST_P2: begin
        mul_a = b2; mul_b = b_r; sh_amt = 5'd11;
        c_nxt = sh_out;
      end
      // x3 = x1 + asr(ac2*b6,11); b3 = sdiv(ac1*4 + x3 + 2, 4)
      bsc_pkg::ST_P3: begin
        mul_a = ac2; mul_b = a_r; sh_amt = 5'd11;
        c_nxt = c_r + sh_out + (ac1 << 2) + W'(2);
      end
      bsc_pkg::ST_P4: begin
        // truncating divide by 4
        mul_a = c_r[W-1] ? (c_r + W'(3)) : c_r; mul_b = W'(1); sh_amt = 5'd2;
        c_nxt = sh_out;
      end
      // x1 = asr(ac3*b6,13)
      bsc_pkg::ST_P5: begin
        mul_a = ac3; mul_b = a_r; sh_amt = 5'd13;
        d_nxt = sh_out;
      end
      // x2 = asr(b1*sq,16); x3 = asr(x1+x2+2, 2) in next step
      bsc_pkg::ST_P6: begin
        mul_a = b1; mul_b = b_r; sh_amt = 5'd16;
        d_nxt = d_r + sh_out + W'(2);
      end
      bsc_pkg::ST_P7: begin
        mul_a = d_r; mul_b = W'(1); sh_amt = 5'd2;
        d_nxt = sh_out + W'(32768);
      end
      // b4 = (ac4 * (x3 + 32768)) >> 15 ; b7 = (raw - b3) * 50000
      bsc_pkg::ST_P8: begin
        mul_a = ac4; mul_b = d_r; sh_amt = 5'd15; sh_arith = 1'b0;
        a_nxt = sh_out;
        if (sh_out == '0) flt_nxt = 1'b1;
      end
      bsc_pkg::ST_PDIV: begin
        mul_a = raw_r - c_r; mul_b = W'(50000);
        neg_nxt = mul_p[W-1];
        dreq.start    = 1'b1;
        dreq.dividend = mul_p[W-1] ? mul_p : (mul_p << 1);
        dreq.divisor  = a_r;
      end
      bsc_pkg::ST_P9: begin
        b_nxt = neg_r ? (drsp.quotient << 1) : drsp.quotient;  // p
      end
      bsc_pkg::ST_P10: begin
        mul_a = b_r; mul_b = W'(1); sh_amt = 5'd8;
        c_nxt = sh_out;
      end
      bsc_pkg::ST_P11: begin
        mul_a = c_r; mul_b = c_r;
        c_nxt = mul_p;
      end
      bsc_pkg::ST_P12: begin
        mul_a = c_r; mul_b = W'(3038); sh_amt = 5'd16;
        c_nxt = sh_out;
      end
      bsc_pkg::ST_P13: begin
        mul_a = W'(0) - W'(7357); mul_b = b_r; sh_amt = 5'd16;
        d_nxt = c_r + sh_out + W'(3791);
        res_nxt = b_r + W'($signed(d_nxt) >>> 4);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bsc_pkg::ST_IDLE;
      b5_r <= '0;
      for (int i = 0; i < bsc_pkg::CalRegs; i++) cal_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (b5_we) b5_r <= d_nxt;
      if (cfg_valid && cfg_ready && (cfg_index < bsc_pkg::CfgIdxW'(bsc_pkg::CalRegs)))
        cal_r[cfg_index] <= cfg_data;
    end
    if (in_tvalid && in_tready) begin
      raw_r <= {{(W-bsc_pkg::RawW){1'b0}}, in_tdata};
      cmd_r <= in_tuser;
    end
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt;
    res_r <= res_nxt; flt_r <= flt_nxt; neg_r <= neg_nxt;
  end

  `ASSERT_IMP(a_fault_zero, clk, rst_n, out_tvalid && out_tuser[1], out_tdata == '0)
  `ASSERT_IMP(a_div_idle, clk, rst_n, drsp.busy, st_r == bsc_pkg::ST_TWAIT || st_r == bsc_pkg::ST_PWAIT)
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule
